FILE: src/bdq_pkg.sv
// bdq_pkg: shared types and constants for the bounded deque with search
// no dependencies; used by the top level bounded_deque_with_search
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int VALUE_W = 64;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_READ       = 3'd4,
        MODE_SEARCH     = 3'd5,
        MODE_REVERSE    = 3'd6
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: src/bdq_ram.sv
// bdq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/bdq_slot.sv
// bdq_slot: shared address unit, maps a position to a physical ring slot
// slot = (base + (from_back ? last - k : k)) mod DEPTH; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bdq_slot #(
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic [AW-1:0] base,
    input  wire logic [CW-1:0] last,
    input  wire logic [CW-1:0] k,
    input  wire logic          from_back,
    output logic      [AW-1:0] slot
);

    logic [CW-1:0] off;
    logic [CW:0]   sum;
    logic [CW:0]   wrapped;

    always_comb begin
        off     = from_back ? (last - k) : k;
        sum     = (CW + 1)'(base) + (CW + 1)'(off);
        // both terms are below DEPTH, so one subtract brings it back in range
        wrapped = (sum >= (CW + 1)'(DEPTH)) ? (sum - (CW + 1)'(DEPTH)) : sum;
        slot    = wrapped[AW-1:0];
    end

endmodule

`default_nettype wire

FILE: src/bounded_deque_with_search.sv
// bounded_deque_with_search: top level, sequencer, pointers and result register
// depends on bdq_pkg, bdq_ram, bdq_slot
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// request   in         s_valid / s_ready  s_mode, s_value, s_index
// result    out        m_valid / m_ready  m_value_res, m_found, m_found_index, m_count, m_status
//
// between accepted requests a push, a reverse or any error passes through exec and done;
// pop and read add one ram read wait state, and a search adds a read and a compare state
// per entry it looks at; the single ram port and the shared slot adder serialise these steps.
// synchronous active-low reset clears pointers, count and direction; the ring
// needs no clearing. a result waiting in the output register does not block
// the next request; only a second finished result waits for m_ready.

module bounded_deque_with_search #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bdq_pkg::MODE_W-1:0]    s_mode,
    input  wire logic [bdq_pkg::VALUE_W-1:0]   s_value,
    input  wire logic [bdq_pkg::INDEX_W-1:0]   s_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bdq_pkg::VALUE_W-1:0]   m_value_res,
    output logic                               m_found,
    output logic      [bdq_pkg::INDEX_W-1:0]   m_found_index,
    output logic      [bdq_pkg::COUNT_W-1:0]   m_count,
    output logic      [bdq_pkg::STAT_W-1:0]    m_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bdq_pkg::state_t  state_reg, state_next;
    bdq_pkg::mode_t   mode_reg;
    bdq_pkg::status_t status_reg, status_next;

    logic [AW-1:0]                 front_reg, front_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          rev_reg, rev_next;
    logic [CW-1:0]                 iter_reg, iter_next;
    logic [DATA_W-1:0]             word_reg;
    logic [bdq_pkg::INDEX_W-1:0]   idx_reg;
    logic [DATA_W-1:0]             rval_reg, rval_next;
    logic                          found_reg, found_next;
    logic [CW-1:0]                 fidx_reg, fidx_next;

    logic                          m_valid_reg;
    logic [DATA_W-1:0]             m_value_reg;
    logic                          m_found_reg;
    logic [CW-1:0]                 m_fidx_reg;
    logic [CW-1:0]                 m_count_reg;
    bdq_pkg::status_t              m_status_reg;

    logic                          accept;
    logic                          out_load;
    logic                          is_full;
    logic                          is_empty;
    logic                          idx_bad;
    logic                          at_tail;
    logic                          last_iter;
    logic                          hit;

    logic                          ram_we;
    logic [DATA_W-1:0]             ram_rdata;
    logic [AW-1:0]                 slot;
    logic [CW-1:0]                 unit_k;
    logic                          unit_fb;

    bdq_slot #(.DEPTH(DEPTH)) u_slot (
        .base      (front_reg),
        .last      (count_reg - CW'(1)),
        .k         (unit_k),
        .from_back (unit_fb),
        .slot      (slot)
    );

    bdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (word_reg),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == bdq_pkg::S_DONE) && (!m_valid_reg || m_ready);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign idx_bad   = (32'(idx_reg) >= 32'(count_reg));
    // back-end requests go to the physical tail unless the order is flipped
    assign at_tail   = ((mode_reg == bdq_pkg::MODE_PUSH_BACK) ||
                        (mode_reg == bdq_pkg::MODE_POP_BACK)) != rev_reg;
    assign last_iter = ((iter_reg + CW'(1)) == count_reg);
    assign hit       = (ram_rdata == word_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = bdq_pkg::S_EXEC;
                end
            end
            bdq_pkg::S_EXEC: begin
                unique case (mode_reg) inside
                    bdq_pkg::MODE_POP_BACK, bdq_pkg::MODE_POP_FRONT: begin
                        state_next = is_empty ? bdq_pkg::S_DONE : bdq_pkg::S_RD_WAIT;
                    end
                    bdq_pkg::MODE_READ: begin
                        state_next = idx_bad ? bdq_pkg::S_DONE : bdq_pkg::S_RD_WAIT;
                    end
                    bdq_pkg::MODE_SEARCH: begin
                        state_next = is_empty ? bdq_pkg::S_DONE : bdq_pkg::S_SRCH_RD;
                    end
                    default: begin
                        state_next = bdq_pkg::S_DONE;
                    end
                endcase
            end
            bdq_pkg::S_RD_WAIT: begin
                state_next = bdq_pkg::S_DONE;
            end
            bdq_pkg::S_SRCH_RD: begin
                state_next = bdq_pkg::S_SRCH_CMP;
            end
            bdq_pkg::S_SRCH_CMP: begin
                state_next = (hit || last_iter) ? bdq_pkg::S_DONE : bdq_pkg::S_SRCH_RD;
            end
            bdq_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath controls and register next values
    always_comb begin
        s_ready     = (state_reg == bdq_pkg::S_IDLE);
        ram_we      = 1'b0;
        unit_k      = '0;
        unit_fb     = 1'b0;
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        iter_next   = iter_reg;
        rval_next   = rval_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        status_next = status_reg;
        unique case (state_reg)
            bdq_pkg::S_IDLE: begin
                rval_next   = '0;
                found_next  = 1'b0;
                fidx_next   = '0;
                status_next = bdq_pkg::ST_OK;
            end
            bdq_pkg::S_EXEC: begin
                iter_next = '0;
                unique case (mode_reg) inside
                    bdq_pkg::MODE_PUSH_BACK, bdq_pkg::MODE_PUSH_FRONT: begin
                        if (is_full) begin
                            status_next = bdq_pkg::ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (at_tail) begin
                                unit_k = count_reg;
                            end else begin
                                // one slot before the front, wrapping
                                unit_k     = CW'(DEPTH - 1);
                                front_next = slot;
                            end
                        end
                    end
                    bdq_pkg::MODE_POP_BACK, bdq_pkg::MODE_POP_FRONT: begin
                        if (is_empty) begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end else begin
                            count_next = count_reg - CW'(1);
                            unit_fb    = at_tail;
                        end
                    end
                    bdq_pkg::MODE_READ: begin
                        if (idx_bad) begin
                            status_next = bdq_pkg::ST_RANGE;
                        end else begin
                            unit_k  = CW'(idx_reg);
                            unit_fb = rev_reg;
                        end
                    end
                    bdq_pkg::MODE_REVERSE: begin
                        rev_next = !rev_reg;
                    end
                    default: begin
                    end
                endcase
            end
            bdq_pkg::S_RD_WAIT: begin
                rval_next = ram_rdata;
                // head pop advances the front once the word is out
                if ((mode_reg == bdq_pkg::MODE_POP_BACK ||
                     mode_reg == bdq_pkg::MODE_POP_FRONT) && !at_tail) begin
                    unit_k     = CW'(1);
                    front_next = slot;
                end
            end
            bdq_pkg::S_SRCH_RD: begin
                unit_k  = iter_reg;
                unit_fb = rev_reg;
            end
            bdq_pkg::S_SRCH_CMP: begin
                if (hit) begin
                    found_next = 1'b1;
                    fidx_next  = iter_reg;
                end else begin
                    iter_next = iter_reg + CW'(1);
                end
            end
            bdq_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdq_pkg::S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= bdq_pkg::mode_t'(s_mode);
            word_reg <= s_value[DATA_W-1:0];
            idx_reg  <= s_index;
        end
        iter_reg   <= iter_next;
        rval_reg   <= rval_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        status_reg <= status_next;
        if (out_load) begin
            m_value_reg  <= rval_reg;
            m_found_reg  <= found_reg;
            m_fidx_reg   <= fidx_reg;
            m_count_reg  <= count_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_res   = bdq_pkg::VALUE_W'(m_value_reg);
    assign m_found       = m_found_reg;
    assign m_found_index = bdq_pkg::INDEX_W'(m_fidx_reg);
    assign m_count       = bdq_pkg::COUNT_W'(m_count_reg);
    assign m_status      = m_status_reg;

endmodule

`default_nettype wire
